// ===== hw/rtl/rde_pkg.sv =====
// shared types and codes for the rectangle draw engine
package rde_pkg;

   localparam int unsigned ADDR_W  = 24;
   localparam int unsigned COORD_W = 12;
   localparam int unsigned COLOR_W = 16;

   typedef enum logic {
      KIND_DRAW = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_BUSY   = 2'd2
   } status_type;

   localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = 24'hC00000;

   typedef struct packed {
      kind_type                   kind;
      logic signed [COORD_W-1:0]  corner_a_x;
      logic signed [COORD_W-1:0]  corner_a_y;
      logic signed [COORD_W-1:0]  corner_b_x;
      logic signed [COORD_W-1:0]  corner_b_y;
      logic        [COLOR_W-1:0]  draw_color;
      logic                       outline_only;
   } req_item_type;

   typedef struct packed {
      logic                write_valid;
      logic [ADDR_W-1:0]   pixel_address;
      logic [COLOR_W-1:0]  pixel_color;
      logic                last_pixel;
      status_type          status;
   } rsp_item_type;

endpackage

// ===== hw/rtl/rde_channels.sv =====
// valid/ready channel interfaces for command and pixel write items
interface rde_req_if;
   logic                  valid;
   logic                  ready;
   rde_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rde_rsp_if;
   logic                  valid;
   logic                  ready;
   rde_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/rectangle_draw_engine_top.sv =====
// rectangle draw engine: corner ordering, clipping and raster pixel write generation
//
//   channel   dir   handshake      carries
//   req_chan  in    valid/ready    draw command or tick item
//   rsp_chan  out   valid/ready    one result item per accepted item
//   csr_*     in    write enable   frame base address
//
// each item's result is computed combinationally from the box and cursor
// registers and lands in the output register on the edge that accepts the item
// one item per clock is sustained while the result side takes every item
// req_chan.ready is high while the output register is empty or being taken
// reset clears the box, cursor and output valid and loads the base address

module rectangle_draw_engine_top #(
   parameter int unsigned SCREEN_COLS = 512,
   parameter int unsigned SCREEN_ROWS = 512,
   parameter int unsigned PIXEL_BYTES = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   rde_req_if.sink                   req_chan,
   rde_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [rde_pkg::ADDR_W-1:0] csr_write_data
);

   localparam int unsigned COL_W     = $clog2(SCREEN_COLS);
   localparam int unsigned ROW_W     = $clog2(SCREEN_ROWS);
   localparam int unsigned ROW_BYTES = SCREEN_COLS * PIXEL_BYTES;
   localparam int unsigned AW        = rde_pkg::ADDR_W;
   localparam int unsigned CW        = rde_pkg::COORD_W;

   localparam logic signed [CW:0] COLS_S   = (CW+1)'(SCREEN_COLS);
   localparam logic signed [CW:0] ROWS_S   = (CW+1)'(SCREEN_ROWS);
   localparam logic [COL_W-1:0]   COL_LAST = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(SCREEN_ROWS - 1);

   logic [AW-1:0]    base_ff;
   logic             busy_ff, busy_in;
   logic [COL_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [ROW_W-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [rde_pkg::COLOR_W-1:0] color_ff, color_in;
   logic             outline_ff, outline_in;

   logic                  rsp_valid_ff;
   rde_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic accept;
   rde_pkg::req_item_type req;

   logic signed [CW-1:0] x_lo, x_hi, y_lo, y_hi;
   logic                 reject;
   logic                 inner;
   logic [AW-1:0]        row_offset, col_offset;

   assign req            = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   // corner ordering and start check
   always_comb begin
      x_lo = (req.corner_a_x > req.corner_b_x) ? req.corner_b_x : req.corner_a_x;
      x_hi = (req.corner_a_x > req.corner_b_x) ? req.corner_a_x : req.corner_b_x;
      y_lo = (req.corner_a_y > req.corner_b_y) ? req.corner_b_y : req.corner_a_y;
      y_hi = (req.corner_a_y > req.corner_b_y) ? req.corner_a_y : req.corner_b_y;
      reject = x_lo[CW-1] || y_lo[CW-1]
            || ($signed({x_lo[CW-1], x_lo}) >= COLS_S)
            || ($signed({y_lo[CW-1], y_lo}) >= ROWS_S);
   end

   // address of the cursor pixel
   assign row_offset = AW'(32'(row_ff) * 32'(ROW_BYTES));
   assign col_offset = AW'(32'(col_ff) * 32'(PIXEL_BYTES));
   assign inner      = (row_ff != top_ff) && (row_ff != bottom_ff);

   always_comb begin
      busy_in     = busy_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      color_in    = color_ff;
      outline_in  = outline_ff;
      rsp_item_in = '{write_valid: 1'b0, pixel_address: '0, pixel_color: '0,
                      last_pixel: 1'b0, status: rde_pkg::STATUS_OK};
      case (req.kind)
         rde_pkg::KIND_DRAW: begin
            if (busy_ff) begin
               rsp_item_in.status = rde_pkg::STATUS_BUSY;
            end else if (reject) begin
               rsp_item_in.status = rde_pkg::STATUS_REJECT;
            end else begin
               left_in    = x_lo[COL_W-1:0];
               top_in     = y_lo[ROW_W-1:0];
               right_in   = ($signed({x_hi[CW-1], x_hi}) >= COLS_S) ? COL_LAST
                                                                   : x_hi[COL_W-1:0];
               bottom_in  = ($signed({y_hi[CW-1], y_hi}) >= ROWS_S) ? ROW_LAST
                                                                   : y_hi[ROW_W-1:0];
               col_in     = x_lo[COL_W-1:0];
               row_in     = y_lo[ROW_W-1:0];
               color_in   = req.draw_color;
               outline_in = req.outline_only;
               busy_in    = 1'b1;
            end
         end
         rde_pkg::KIND_TICK: begin
            if (busy_ff) begin
               rsp_item_in.write_valid   = 1'b1;
               rsp_item_in.pixel_address = base_ff + row_offset + col_offset;
               rsp_item_in.pixel_color   = color_ff;
               // outline inner rows jump from the left side straight to the right
               if (outline_ff && inner && col_ff == left_ff && right_ff > left_ff) begin
                  col_in = right_ff;
               end else if (col_ff < right_ff && !(outline_ff && inner)) begin
                  col_in = col_ff + COL_W'(1);
               end else if (row_ff < bottom_ff) begin
                  row_in = row_ff + ROW_W'(1);
                  col_in = left_ff;
               end else begin
                  rsp_item_in.last_pixel = 1'b1;
                  busy_in                = 1'b0;
               end
            end
         end
         default: begin
            rsp_item_in.status = rde_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= rde_pkg::FRAME_BASE_RESET;
         busy_ff      <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
         top_ff       <= '0;
         bottom_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         color_ff     <= '0;
         outline_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         if (accept) begin
            busy_ff      <= busy_in;
            left_ff      <= left_in;
            right_ff     <= right_in;
            top_ff       <= top_in;
            bottom_ff    <= bottom_in;
            col_ff       <= col_in;
            row_ff       <= row_in;
            color_ff     <= color_in;
            outline_ff   <= outline_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // a draw item that arrives mid-rectangle is refused
   a_busy_refuse: assert property (@(posedge clock) disable iff (reset)
      accept && req.kind == rde_pkg::KIND_DRAW && busy_ff
      |=> rsp_valid_ff && rsp_item_ff.status == rde_pkg::STATUS_BUSY && busy_ff)
      else $error("draw item while busy not refused");

   // cursor stays inside the latched box
   a_cursor_in_box: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> col_ff >= left_ff && col_ff <= right_ff
               && row_ff >= top_ff && row_ff <= bottom_ff)
      else $error("cursor left the box");

   // final write ends the rectangle
   a_last_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.last_pixel |-> !busy_ff && rsp_item_ff.write_valid)
      else $error("last pixel without end of rectangle");

   // idle ticks produce no write
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      accept && req.kind == rde_pkg::KIND_TICK && !busy_ff
      |=> !rsp_item_ff.write_valid && !busy_ff)
      else $error("write produced while idle");

endmodule
